FILE: rtl/pts_pkg.sv
package pts_pkg;

	// stream payload widths (whole bytes)
	localparam int IN_W   = 64;
	localparam int OUT_W  = 40;

	// request field widths
	localparam int OP_W      = 3;
	localparam int ID_W      = 4;
	localparam int PRIO_IN_W = 5;
	localparam int SLICE_W   = 16;
	localparam int DELAY_W   = 32;
	localparam int MASK_W    = 32;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE = 3'd0,
		OP_READY  = 3'd1,
		OP_DELAY  = 3'd2,
		OP_TICK   = 3'd3,
		OP_SCHED  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_SUSP  = 2'd0,
		ST_READY = 2'd1,
		ST_RUN   = 2'd2,
		ST_BLOCK = 2'd3
	} task_state_t;

endpackage

FILE: rtl/priority_task_scheduler.sv
// Priority task scheduler with round-robin time slicing.
//
// Requests enter on the s_ group (create, make ready, delay, tick, schedule);
// every request gives exactly one result on the m_ group: the running task,
// whether one runs, whether this request switched it, and the ready mask.
//
// Task records and per-priority queue heads/tails live in two synchronous
// memories (registered read). A sequencer reads, modifies and writes back one
// record at a time, so a request takes longer for every list entry walked,
// and ignored requests are the shortest. A tick visits every delayed task
// and makes ready each task it wakes, with a delay-list walk for each.
// One request is worked on at a time; s_tready is high only while the
// sequencer is idle.
//
// The result sits in an output register: the next request is accepted while
// a result still waits, and the sequencer holds its last step until the
// receiver takes the earlier one. Reset clears all control state, the ready
// mask, the delay list and marks every task suspended (per-task written bits);
// no clearing pass is needed.
module priority_task_scheduler #(
	parameter int TASKS      = 16,
	parameter int PRIORITIES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// operation[2:0], task_id[6:3], priority_req[11:7], slice_reload[27:12],
	// delay_ticks[59:28], zero fill [63:60]
	input  logic [pts_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// running_task[3:0], running_valid[4], switched[5], ready_mask[37:6],
	// zero fill [39:38]
	output logic [pts_pkg::OUT_W-1:0]  m_tdata
);
	import pts_pkg::*;

	localparam int TW = $clog2(TASKS);
	localparam int CW = $clog2(TASKS + 1);
	localparam int PW = $clog2(PRIORITIES);

	typedef struct packed {
		logic [PW-1:0]      prio;
		task_state_t        status;
		logic [DELAY_W-1:0] dleft;
		logic [SLICE_W-1:0] sleft;
		logic [SLICE_W-1:0] sfull;
		logic [TW-1:0]      rlink;
		logic [TW-1:0]      dlink;
	} task_word_t;

	typedef struct packed {
		logic [TW-1:0] first;
		logic [TW-1:0] last;
	} queue_ent_t;

	typedef enum logic [38:0] {
		S_IDLE      = 39'd1 << 0,
		S_DISP      = 39'd1 << 1,
		S_C_RD      = 39'd1 << 2,
		S_C_CHK     = 39'd1 << 3,
		S_C_RD2     = 39'd1 << 4,
		S_C_WR      = 39'd1 << 5,
		S_MR_RD     = 39'd1 << 6,
		S_MR_CHK    = 39'd1 << 7,
		S_MR_RD2    = 39'd1 << 8,
		S_MR_WR     = 39'd1 << 9,
		S_D_RD      = 39'd1 << 10,
		S_D_CHK     = 39'd1 << 11,
		S_D_RD2     = 39'd1 << 12,
		S_D_WR      = 39'd1 << 13,
		S_K_RD      = 39'd1 << 14,
		S_K_CHK     = 39'd1 << 15,
		S_K_APP     = 39'd1 << 16,
		S_K_DL      = 39'd1 << 17,
		S_K_LOOP    = 39'd1 << 18,
		S_K_ELEM    = 39'd1 << 19,
		S_RS_BEGIN  = 39'd1 << 20,
		S_RS_Q      = 39'd1 << 21,
		S_RS_OLD    = 39'd1 << 22,
		S_RS_NEW_RD = 39'd1 << 23,
		S_RS_NEW    = 39'd1 << 24,
		S_QR_BEGIN  = 39'd1 << 25,
		S_QR_HEAD   = 39'd1 << 26,
		S_QR_WALK   = 39'd1 << 27,
		S_QR_LINK   = 39'd1 << 28,
		S_QA_BEGIN  = 39'd1 << 29,
		S_QA_Q      = 39'd1 << 30,
		S_QA_LNK    = 39'd1 << 31,
		S_DR_BEGIN  = 39'd1 << 32,
		S_DR_T      = 39'd1 << 33,
		S_DR_WALK   = 39'd1 << 34,
		S_DR_LINK   = 39'd1 << 35,
		S_DA_BEGIN  = 39'd1 << 36,
		S_DA_LNK    = 39'd1 << 37,
		S_FIN       = 39'd1 << 38
	} state_t;

	// sequencer state and return points
	state_t state_q, state_d;
	state_t lret_q, lret_d;   // return from list routines
	state_t mret_q, mret_d;   // return from make-ready

	// captured request
	logic [OP_W-1:0]      op_q;
	logic [ID_W-1:0]      id_q;
	logic [PRIO_IN_W-1:0] pr_q;
	logic [SLICE_W-1:0]   sl_q;
	logic [DELAY_W-1:0]   dl_q;

	// working registers
	logic [TW-1:0] t_q, t_d;
	logic [TW-1:0] lt_q, lt_d;
	logic [PW-1:0] lp_q, lp_d;
	logic [TW-1:0] lnk_q, lnk_d;
	logic [TW-1:0] prev_q, prev_d;
	logic [TW-1:0] qf_q, qf_d;
	logic [TW-1:0] ql_q, ql_d;
	logic [TW-1:0] wt_q, wt_d;
	logic [TW-1:0] nxt_q, nxt_d;
	logic [CW-1:0] i_q, i_d;
	logic [CW-1:0] k_q, k_d;
	logic [CW-1:0] n_q, n_d;

	// scheduler state kept in flops
	logic [PRIORITIES-1:0] ready_bits_q, ready_bits_d;
	logic [TW-1:0]         dfirst_q, dfirst_d;
	logic [TW-1:0]         dlast_q, dlast_d;
	logic [CW-1:0]         dcount_q, dcount_d;
	logic [TW-1:0]         cur_q, cur_d;
	logic                  cur_valid_q, cur_valid_d;
	logic [TW-1:0]         old_task_q;
	logic                  old_valid_q;
	logic [TASKS-1:0]      written_q;

	// result register
	logic               m_tvalid_q;
	logic [ID_W-1:0]    out_task_q;
	logic               out_valid_q;
	logic               out_sw_q;
	logic [MASK_W-1:0]  out_mask_q;

	// task record memory
	task_word_t tmem [TASKS];
	task_word_t t_rd_q;
	logic       t_rdv_q;
	logic [TW-1:0] t_ra, t_wa;
	logic          t_we;
	task_word_t    t_wd;
	task_word_t    tw;

	// queue head/tail memory
	queue_ent_t qmem [PRIORITIES];
	queue_ent_t q_rd_q;
	logic [PW-1:0] q_ra, q_wa;
	logic          q_we;
	queue_ent_t    q_wd;

	logic          id_ok;
	logic [TW-1:0] id_t;
	logic [PW-1:0] pr_sat;
	logic [PW-1:0] hp;
	logic          fin_go;

	assign s_tready = (state_q == S_IDLE);
	assign fin_go   = (state_q == S_FIN) && (!m_tvalid_q || m_tready);

	assign id_ok  = {{(32 - ID_W){1'b0}}, id_q} < 32'(TASKS);
	assign id_t   = TW'(id_q);
	assign pr_sat = ({{(32 - PRIO_IN_W){1'b0}}, pr_q} >= 32'(PRIORITIES)) ?
		PW'(PRIORITIES - 1) : PW'(pr_q);

	// a never-written record reads as suspended with no delay left
	always_comb begin
		tw = t_rd_q;
		if (!t_rdv_q) begin
			tw.status = ST_SUSP;
			tw.dleft  = '0;
		end
	end

	// highest non-empty priority
	always_comb begin
		hp = '0;
		for (int p = 0; p < PRIORITIES; p++) begin
			if (ready_bits_q[p]) hp = PW'(p);
		end
	end

	always_comb begin
		state_d      = state_q;
		lret_d       = lret_q;
		mret_d       = mret_q;
		t_d          = t_q;
		lt_d         = lt_q;
		lp_d         = lp_q;
		lnk_d        = lnk_q;
		prev_d       = prev_q;
		qf_d         = qf_q;
		ql_d         = ql_q;
		wt_d         = wt_q;
		nxt_d        = nxt_q;
		i_d          = i_q;
		k_d          = k_q;
		n_d          = n_q;
		ready_bits_d = ready_bits_q;
		dfirst_d     = dfirst_q;
		dlast_d      = dlast_q;
		dcount_d     = dcount_q;
		cur_d        = cur_q;
		cur_valid_d  = cur_valid_q;
		t_ra = t_q;
		t_we = 1'b0;
		t_wa = t_q;
		t_wd = tw;
		q_ra = lp_q;
		q_we = 1'b0;
		q_wa = lp_q;
		q_wd = q_rd_q;

		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_DISP;
			end
			S_DISP: begin
				case (op_t'(op_q))
					OP_CREATE: begin
						if (id_ok) begin
							t_d = id_t;
							state_d = S_C_RD;
						end else begin
							state_d = S_FIN;
						end
					end
					OP_READY: begin
						if (id_ok) begin
							lt_d = id_t;
							mret_d = S_FIN;
							state_d = S_MR_RD;
						end else begin
							state_d = S_FIN;
						end
					end
					OP_DELAY: begin
						if (dl_q != '0 && cur_valid_q) begin
							t_d = cur_q;
							state_d = S_D_RD;
						end else begin
							state_d = S_FIN;
						end
					end
					OP_TICK: begin
						if (cur_valid_q) begin
							t_d = cur_q;
							state_d = S_K_RD;
						end else begin
							state_d = S_FIN;
						end
					end
					OP_SCHED: state_d = S_RS_BEGIN;
					default:  state_d = S_FIN;
				endcase
			end

			// create: unlink, then rewrite the record
			S_C_RD: begin
				t_ra = t_q;
				state_d = S_C_CHK;
			end
			S_C_CHK: begin
				lt_d = t_q;
				lp_d = tw.prio;
				lret_d = S_C_RD2;
				if (tw.status inside {ST_READY, ST_RUN}) state_d = S_QR_BEGIN;
				else if (tw.status == ST_BLOCK) state_d = S_DR_BEGIN;
				else state_d = S_C_RD2;
			end
			S_C_RD2: begin
				t_ra = t_q;
				state_d = S_C_WR;
			end
			S_C_WR: begin
				t_we = 1'b1;
				t_wa = t_q;
				t_wd.prio = pr_sat;
				t_wd.status = ST_SUSP;
				t_wd.dleft = '0;
				t_wd.sleft = sl_q;
				t_wd.sfull = sl_q;
				if (cur_valid_q && cur_q == t_q) cur_valid_d = 1'b0;
				state_d = S_FIN;
			end

			// make ready of task lt
			S_MR_RD: begin
				t_ra = lt_q;
				state_d = S_MR_CHK;
			end
			S_MR_CHK: begin
				lret_d = S_MR_RD2;
				if (tw.status inside {ST_READY, ST_RUN}) state_d = mret_q;
				else if (tw.status == ST_BLOCK) state_d = S_DR_BEGIN;
				else state_d = S_MR_RD2;
			end
			S_MR_RD2: begin
				t_ra = lt_q;
				state_d = S_MR_WR;
			end
			S_MR_WR: begin
				t_we = 1'b1;
				t_wa = lt_q;
				t_wd.status = ST_READY;
				lp_d = tw.prio;
				lret_d = mret_q;
				state_d = S_QA_BEGIN;
			end

			// delay current task
			S_D_RD: begin
				t_ra = t_q;
				state_d = S_D_CHK;
			end
			S_D_CHK: begin
				lt_d = t_q;
				lp_d = tw.prio;
				lret_d = S_D_RD2;
				if (tw.status inside {ST_READY, ST_RUN}) state_d = S_QR_BEGIN;
				else if (tw.status == ST_BLOCK) state_d = S_DR_BEGIN;
				else state_d = S_D_RD2;
			end
			S_D_RD2: begin
				t_ra = t_q;
				state_d = S_D_WR;
			end
			S_D_WR: begin
				t_we = 1'b1;
				t_wa = t_q;
				t_wd.dleft = dl_q;
				t_wd.status = ST_BLOCK;
				lt_d = t_q;
				lret_d = S_RS_BEGIN;
				state_d = S_DA_BEGIN;
			end

			// tick: slice of the running task, then the delay list
			S_K_RD: begin
				t_ra = t_q;
				state_d = S_K_CHK;
			end
			S_K_CHK: begin
				state_d = S_K_DL;
				if (tw.status == ST_RUN && tw.sfull != '0 && tw.sleft != '0) begin
					t_we = 1'b1;
					t_wa = t_q;
					if (tw.sleft == SLICE_W'(1)) begin
						t_wd.sleft = tw.sfull;
						lt_d = t_q;
						lp_d = tw.prio;
						lret_d = S_K_APP;
						state_d = S_QR_BEGIN;
					end else begin
						t_wd.sleft = tw.sleft - SLICE_W'(1);
					end
				end
			end
			S_K_APP: begin
				lret_d = S_K_DL;
				state_d = S_QA_BEGIN;
			end
			S_K_DL: begin
				n_d = dcount_q;
				wt_d = dfirst_q;
				k_d = '0;
				state_d = S_K_LOOP;
			end
			S_K_LOOP: begin
				if (k_q < n_q) begin
					t_ra = wt_q;
					state_d = S_K_ELEM;
				end else begin
					state_d = S_RS_BEGIN;
				end
			end
			S_K_ELEM: begin
				k_d = k_q + CW'(1);
				wt_d = tw.dlink;
				state_d = S_K_LOOP;
				if (tw.dleft != '0) begin
					t_we = 1'b1;
					t_wa = wt_q;
					t_wd.dleft = tw.dleft - DELAY_W'(1);
					if (tw.dleft == DELAY_W'(1)) begin
						lt_d = wt_q;
						mret_d = S_K_LOOP;
						state_d = S_MR_RD;
					end
				end
			end

			// reschedule
			S_RS_BEGIN: begin
				if (ready_bits_q == '0) begin
					cur_valid_d = 1'b0;
					state_d = S_FIN;
				end else begin
					q_ra = hp;
					state_d = S_RS_Q;
				end
			end
			S_RS_Q: begin
				nxt_d = q_rd_q.first;
				if (cur_valid_q && q_rd_q.first == cur_q) begin
					state_d = S_FIN;
				end else if (cur_valid_q) begin
					t_ra = cur_q;
					state_d = S_RS_OLD;
				end else begin
					state_d = S_RS_NEW_RD;
				end
			end
			S_RS_OLD: begin
				if (tw.status == ST_RUN) begin
					t_we = 1'b1;
					t_wa = cur_q;
					t_wd.status = ST_READY;
				end
				state_d = S_RS_NEW_RD;
			end
			S_RS_NEW_RD: begin
				t_ra = nxt_q;
				state_d = S_RS_NEW;
			end
			S_RS_NEW: begin
				t_we = 1'b1;
				t_wa = nxt_q;
				t_wd.status = ST_RUN;
				cur_d = nxt_q;
				cur_valid_d = 1'b1;
				state_d = S_FIN;
			end

			// unlink lt from ready queue lp
			S_QR_BEGIN: begin
				if (!ready_bits_q[lp_q]) begin
					state_d = lret_q;
				end else begin
					t_ra = lt_q;
					q_ra = lp_q;
					state_d = S_QR_HEAD;
				end
			end
			S_QR_HEAD: begin
				lnk_d = tw.rlink;
				qf_d = q_rd_q.first;
				ql_d = q_rd_q.last;
				state_d = lret_q;
				if (q_rd_q.first == lt_q) begin
					if (q_rd_q.last == lt_q) begin
						ready_bits_d[lp_q] = 1'b0;
					end else begin
						q_we = 1'b1;
						q_wa = lp_q;
						q_wd.first = tw.rlink;
						q_wd.last = q_rd_q.last;
					end
				end else begin
					prev_d = q_rd_q.first;
					i_d = '0;
					state_d = S_QR_WALK;
				end
			end
			S_QR_WALK: begin
				if (i_q < CW'(TASKS) && prev_q != ql_q) begin
					t_ra = prev_q;
					state_d = S_QR_LINK;
				end else begin
					state_d = lret_q;
				end
			end
			S_QR_LINK: begin
				if (tw.rlink == lt_q) begin
					t_we = 1'b1;
					t_wa = prev_q;
					t_wd.rlink = lnk_q;
					if (ql_q == lt_q) begin
						q_we = 1'b1;
						q_wa = lp_q;
						q_wd.first = qf_q;
						q_wd.last = prev_q;
					end
					state_d = lret_q;
				end else begin
					prev_d = tw.rlink;
					i_d = i_q + CW'(1);
					state_d = S_QR_WALK;
				end
			end

			// append lt to ready queue lp
			S_QA_BEGIN: begin
				if (ready_bits_q[lp_q]) begin
					q_ra = lp_q;
					state_d = S_QA_Q;
				end else begin
					q_we = 1'b1;
					q_wa = lp_q;
					q_wd.first = lt_q;
					q_wd.last = lt_q;
					ready_bits_d[lp_q] = 1'b1;
					state_d = lret_q;
				end
			end
			S_QA_Q: begin
				qf_d = q_rd_q.first;
				ql_d = q_rd_q.last;
				t_ra = q_rd_q.last;
				state_d = S_QA_LNK;
			end
			S_QA_LNK: begin
				t_we = 1'b1;
				t_wa = ql_q;
				t_wd.rlink = lt_q;
				q_we = 1'b1;
				q_wa = lp_q;
				q_wd.first = qf_q;
				q_wd.last = lt_q;
				state_d = lret_q;
			end

			// unlink lt from the delay list
			S_DR_BEGIN: begin
				if (dcount_q == '0) begin
					state_d = lret_q;
				end else begin
					t_ra = lt_q;
					state_d = S_DR_T;
				end
			end
			S_DR_T: begin
				lnk_d = tw.dlink;
				state_d = lret_q;
				if (dfirst_q == lt_q) begin
					dfirst_d = tw.dlink;
					dcount_d = dcount_q - CW'(1);
				end else begin
					prev_d = dfirst_q;
					i_d = CW'(1);
					state_d = S_DR_WALK;
				end
			end
			S_DR_WALK: begin
				if (i_q < dcount_q) begin
					t_ra = prev_q;
					state_d = S_DR_LINK;
				end else begin
					state_d = lret_q;
				end
			end
			S_DR_LINK: begin
				if (tw.dlink == lt_q) begin
					t_we = 1'b1;
					t_wa = prev_q;
					t_wd.dlink = lnk_q;
					if (dlast_q == lt_q) dlast_d = prev_q;
					dcount_d = dcount_q - CW'(1);
					state_d = lret_q;
				end else begin
					prev_d = tw.dlink;
					i_d = i_q + CW'(1);
					state_d = S_DR_WALK;
				end
			end

			// append lt to the delay list
			S_DA_BEGIN: begin
				if (dcount_q == '0) begin
					dfirst_d = lt_q;
					dlast_d = lt_q;
					dcount_d = dcount_q + CW'(1);
					state_d = lret_q;
				end else begin
					t_ra = dlast_q;
					state_d = S_DA_LNK;
				end
			end
			S_DA_LNK: begin
				t_we = 1'b1;
				t_wa = dlast_q;
				t_wd.dlink = lt_q;
				dlast_d = lt_q;
				dcount_d = dcount_q + CW'(1);
				state_d = lret_q;
			end

			S_FIN: begin
				if (fin_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// task record memory
	always_ff @(posedge clk) begin
		if (t_we) tmem[t_wa] <= t_wd;
		t_rd_q <= tmem[t_ra];
	end

	// queue head/tail memory
	always_ff @(posedge clk) begin
		if (q_we) qmem[q_wa] <= q_wd;
		q_rd_q <= qmem[q_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lret_q       <= S_FIN;
			mret_q       <= S_FIN;
			ready_bits_q <= '0;
			dfirst_q     <= '0;
			dlast_q      <= '0;
			dcount_q     <= '0;
			cur_q        <= '0;
			cur_valid_q  <= 1'b0;
			written_q    <= '0;
			t_rdv_q      <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			lret_q       <= lret_d;
			mret_q       <= mret_d;
			ready_bits_q <= ready_bits_d;
			dfirst_q     <= dfirst_d;
			dlast_q      <= dlast_d;
			dcount_q     <= dcount_d;
			cur_q        <= cur_d;
			cur_valid_q  <= cur_valid_d;
			t_rdv_q      <= written_q[t_ra];
			if (t_we) written_q[t_wa] <= 1'b1;
			// hold the result until taken, then drop valid
			if (fin_go) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// payload and working registers, no reset needed
	always_ff @(posedge clk) begin
		t_q    <= t_d;
		lt_q   <= lt_d;
		lp_q   <= lp_d;
		lnk_q  <= lnk_d;
		prev_q <= prev_d;
		qf_q   <= qf_d;
		ql_q   <= ql_d;
		wt_q   <= wt_d;
		nxt_q  <= nxt_d;
		i_q    <= i_d;
		k_q    <= k_d;
		n_q    <= n_d;
		if (s_tvalid && s_tready) begin
			op_q        <= s_tdata[2:0];
			id_q        <= s_tdata[6:3];
			pr_q        <= s_tdata[11:7];
			sl_q        <= s_tdata[27:12];
			dl_q        <= s_tdata[59:28];
			old_task_q  <= cur_q;
			old_valid_q <= cur_valid_q;
		end
		if (fin_go) begin
			out_task_q  <= cur_valid_q ? ID_W'(cur_q) : '0;
			out_valid_q <= cur_valid_q;
			out_sw_q    <= (old_valid_q != cur_valid_q) ||
				(cur_valid_q && old_task_q != cur_q);
			out_mask_q  <= MASK_W'(ready_bits_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_mask_q, out_sw_q, out_valid_q, out_task_q};

	// a running task always sits in some non-empty ready queue
	a_run_has_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cur_valid_q) |-> (ready_bits_q != '0))
		else $error("running task without a ready queue");

	// the delay list never holds more than every task
	a_dcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcount_q <= CW'(TASKS))
		else $error("delay list count overflow");

	// a finished result waits while the receiver stalls
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && m_tvalid && !m_tready) |=> (state_q == S_FIN))
		else $error("result overwritten while stalled");

endmodule

FILE: test/priority_task_scheduler_tb.sv
module priority_task_scheduler_tb;
	import pts_pkg::*;

	localparam int NTASK = 16;
	localparam int NPRIO = 32;
	localparam int LIMIT = 3000000;

	typedef struct packed {
		logic [DELAY_W-1:0]   dly;
		logic [SLICE_W-1:0]   slice;
		logic [PRIO_IN_W-1:0] prio;
		logic [ID_W-1:0]      id;
		logic [OP_W-1:0]      op;
	} sched_req_t;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic              switched;
		logic              valid;
		logic [ID_W-1:0]   task_id;
	} sched_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	always #2 clk = ~clk;

	priority_task_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// scheduler mirror
	logic [4:0]  t_prio [NTASK];
	task_state_t t_state [NTASK];
	logic [31:0] t_dleft [NTASK];
	logic [15:0] t_sleft [NTASK];
	logic [15:0] t_sfull [NTASK];
	logic [3:0]  rlink [NTASK];
	logic [3:0]  qhead [NPRIO];
	logic [3:0]  qtail [NPRIO];
	logic [3:0]  dlink [NTASK];
	logic [3:0]  dhead, dtail;
	int          dcnt;
	logic [31:0] rbits;
	logic [3:0]  cur;
	logic        cur_ok;
	bit          created [NTASK];

	sched_req_t pending_reqs[$];
	sched_res_t expected_results[$];
	int errors = 0;
	int cycles = 0;
	int results_seen = 0;
	int requests_sent = 0;
	bit stim_done = 0;
	bit hold_off = 0;

	function automatic void rq_append(logic [3:0] t);
		logic [4:0] p;
		p = t_prio[t];
		if (rbits[p]) rlink[qtail[p]] = t;
		else begin
			qhead[p] = t;
			rbits[p] = 1'b1;
		end
		qtail[p] = t;
	endfunction

	function automatic void rq_unlink(logic [3:0] t);
		logic [4:0] p;
		logic [3:0] prv;
		p = t_prio[t];
		if (!rbits[p]) return;
		if (qhead[p] == t) begin
			if (qtail[p] == t) rbits[p] = 1'b0;
			else qhead[p] = rlink[t];
			return;
		end
		prv = qhead[p];
		for (int i = 0; i < NTASK && prv != qtail[p]; i++) begin
			if (rlink[prv] == t) begin
				rlink[prv] = rlink[t];
				if (qtail[p] == t) qtail[p] = prv;
				return;
			end
			prv = rlink[prv];
		end
	endfunction

	function automatic void dl_append(logic [3:0] t);
		if (dcnt == 0) dhead = t;
		else dlink[dtail] = t;
		dtail = t;
		dcnt++;
	endfunction

	function automatic void dl_unlink(logic [3:0] t);
		logic [3:0] prv;
		if (dcnt == 0) return;
		if (dhead == t) begin
			dhead = dlink[t];
			dcnt--;
			return;
		end
		prv = dhead;
		for (int i = 1; i < dcnt; i++) begin
			if (dlink[prv] == t) begin
				dlink[prv] = dlink[t];
				if (dtail == t) dtail = prv;
				dcnt--;
				return;
			end
			prv = dlink[prv];
		end
	endfunction

	function automatic void wake(logic [3:0] t);
		if (t_state[t] == ST_READY || t_state[t] == ST_RUN) return;
		if (t_state[t] == ST_BLOCK) dl_unlink(t);
		t_state[t] = ST_READY;
		rq_append(t);
	endfunction

	function automatic void pick_next();
		int p;
		logic [3:0] nx;
		if (rbits == 0) begin
			cur_ok = 1'b0;
			return;
		end
		p = NPRIO - 1;
		while (p > 0 && !rbits[p]) p--;
		nx = qhead[p];
		if (cur_ok && nx == cur) return;
		if (cur_ok && t_state[cur] == ST_RUN) t_state[cur] = ST_READY;
		t_state[nx] = ST_RUN;
		cur = nx;
		cur_ok = 1'b1;
	endfunction

	function automatic void tick_all();
		logic [3:0] t, nx;
		int n;
		if (t_state[cur] == ST_RUN && t_sfull[cur] > 0 && t_sleft[cur] > 0) begin
			t_sleft[cur]--;
			if (t_sleft[cur] == 0) begin
				t_sleft[cur] = t_sfull[cur];
				rq_unlink(cur);
				rq_append(cur);
			end
		end
		n = dcnt;
		t = dhead;
		for (int i = 0; i < n; i++) begin
			nx = dlink[t];
			if (t_dleft[t] > 0) begin
				t_dleft[t]--;
				if (t_dleft[t] == 0) wake(t);
			end
			t = nx;
		end
		pick_next();
	endfunction

	function automatic sched_res_t schedule_step(sched_req_t r);
		sched_res_t res;
		logic was_ok;
		logic [3:0] was_cur, t;
		was_ok = cur_ok;
		was_cur = cur;
		t = r.id;
		case (r.op)
			OP_CREATE: begin
				if (t_state[t] == ST_READY || t_state[t] == ST_RUN) rq_unlink(t);
				else if (t_state[t] == ST_BLOCK) dl_unlink(t);
				if (cur_ok && cur == t) cur_ok = 1'b0;
				t_prio[t] = r.prio;
				t_dleft[t] = 0;
				t_state[t] = ST_SUSP;
				t_sfull[t] = r.slice;
				t_sleft[t] = r.slice;
			end
			OP_READY: wake(t);
			OP_DELAY: begin
				if (r.dly != 0 && cur_ok) begin
					t_dleft[cur] = r.dly;
					if (t_state[cur] == ST_READY || t_state[cur] == ST_RUN)
						rq_unlink(cur);
					else if (t_state[cur] == ST_BLOCK) dl_unlink(cur);
					t_state[cur] = ST_BLOCK;
					dl_append(cur);
					pick_next();
				end
			end
			OP_TICK: if (cur_ok) tick_all();
			OP_SCHED: pick_next();
			default: ;
		endcase
		res.task_id = cur_ok ? cur : '0;
		res.valid = cur_ok;
		res.switched = (was_ok != cur_ok) || (cur_ok && was_cur != cur);
		res.mask = rbits;
		return res;
	endfunction

	// queue a request; make ready only targets created tasks
	task automatic push_req(logic [2:0] op, logic [3:0] id, logic [4:0] prio,
			logic [15:0] slice, logic [31:0] dly);
		sched_req_t r;
		r.op = op; r.id = id; r.prio = prio; r.slice = slice; r.dly = dly;
		if (op == OP_CREATE) created[id] = 1;
		pending_reqs.push_back(r);
	endtask

	function automatic logic [31:0] rand_delay();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF;
			2: return 32'd0;
			default: return 32'($urandom_range(1, 6));
		endcase
	endfunction

	// driver: one request at a time, random gap after each
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				requests_sent <= requests_sent + 1;
				expected_results.push_back(schedule_step(sched_req_t'(s_tdata[59:0])));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || pending_reqs.size() == 0) begin
					s_tvalid <= 1'b0;
					if (gap_left > 0) gap_left <= gap_left - 1;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, pending_reqs.pop_front()};
					gap_left <= $urandom_range(0, 7);
				end
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	int stall_left = 0;
	always @(posedge clk) begin
		sched_res_t got, want;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (m_tvalid && m_tready) begin
				got = sched_res_t'(m_tdata[37:0]);
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.task_id !== want.task_id) begin
						$error("running_task exp %0d got %0d", want.task_id, got.task_id);
						errors++;
					end
					if (got.valid !== want.valid) begin
						$error("running_valid exp %0d got %0d", want.valid, got.valid);
						errors++;
					end
					if (got.switched !== want.switched) begin
						$error("switched exp %0d got %0d", want.switched, got.switched);
						errors++;
					end
					if (got.mask !== want.mask) begin
						$error("ready_mask exp %h got %h", want.mask, got.mask);
						errors++;
					end
				end
			end
			// draw a new stall after each accepted result; hold off on request
			if (hold_off) m_tready <= 1'b0;
			else if (m_tvalid && m_tready) begin
				stall_left = $urandom_range(0, 7);
				m_tready <= (stall_left == 0);
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
				m_tready <= (stall_left == 0);
			end else m_tready <= 1'b1;
		end
	end

	// long receiver hold-off: let the block fill and stall its input
	initial begin
		wait (requests_sent >= 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		logic [3:0] id;
		int k;
		dhead = 0; dtail = 0; dcnt = 0; rbits = 0; cur = 0; cur_ok = 0;
		for (int i = 0; i < NTASK; i++) begin
			t_state[i] = ST_SUSP; t_dleft[i] = 0; t_prio[i] = 0;
			t_sleft[i] = 0; t_sfull[i] = 0; rlink[i] = 0; dlink[i] = 0; created[i] = 0;
		end
		for (int i = 0; i < NPRIO; i++) begin
			qhead[i] = 0; qtail[i] = 0;
		end

		// directed: empty schedule, tick and delay with nothing running
		push_req(OP_SCHED, 4'd0, 5'd0, 16'd0, 32'd0);
		push_req(OP_TICK, 4'd0, 5'd0, 16'd0, 32'd0);
		push_req(OP_DELAY, 4'd0, 5'd0, 16'd0, 32'd5);
		// extremes of priority and slice, all bits toggled
		push_req(OP_CREATE, 4'd15, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
		push_req(OP_CREATE, 4'd0, 5'd0, 16'd0, 32'd0);
		push_req(OP_CREATE, 4'd5, 5'd10, 16'd1, 32'd0);
		push_req(OP_CREATE, 4'd6, 5'd10, 16'd2, 32'd0);
		push_req(OP_READY, 4'd0, 5'd0, 16'd0, 32'd0);
		push_req(OP_READY, 4'd5, 5'd0, 16'd0, 32'd0);
		push_req(OP_READY, 4'd6, 5'd0, 16'd0, 32'd0);
		push_req(OP_SCHED, 4'd0, 5'd0, 16'd0, 32'd0);
		push_req(OP_READY, 4'd5, 5'd0, 16'd0, 32'd0);  // already running
		push_req(OP_TICK, 4'd0, 5'd0, 16'd0, 32'd0);   // slice rotates
		push_req(OP_DELAY, 4'd0, 5'd0, 16'd0, 32'd0);  // zero ticks
		push_req(OP_DELAY, 4'd0, 5'd0, 16'd0, 32'd2);
		push_req(OP_TICK, 4'd0, 5'd0, 16'd0, 32'd0);
		push_req(OP_TICK, 4'd0, 5'd0, 16'd0, 32'd0);
		push_req(OP_READY, 4'd15, 5'd0, 16'd0, 32'd0);
		push_req(OP_SCHED, 4'd0, 5'd0, 16'd0, 32'd0);
		push_req(OP_DELAY, 4'd0, 5'd0, 16'd0, 32'hFFFF_FFFF);
		push_req(OP_READY, 4'd15, 5'd0, 16'd0, 32'd0); // unblock early
		push_req(OP_CREATE, 4'd15, 5'd3, 16'd0, 32'd0); // create on queued
		push_req(OP_SCHED, 4'd0, 5'd0, 16'd0, 32'd0);
		push_req(3'd7, 4'd9, 5'd21, 16'h5A5A, 32'h1234_5678);
		push_req(3'd5, 4'd0, 5'd0, 16'd0, 32'd0);

		// random: mostly well-formed traffic over created tasks
		k = 0;
		while (k < 1400) begin
			wait (pending_reqs.size() < 8);
			id = 4'($urandom_range(0, NTASK - 1));
			case ($urandom_range(0, 19))
				0, 1: push_req(OP_CREATE, id, ($urandom_range(0, 3) == 0) ? 5'($urandom())
					: 5'($urandom_range(0, 4)), ($urandom_range(0, 4) == 0) ?
					16'($urandom()) : 16'($urandom_range(0, 3)), $urandom());
				2, 3, 4, 5: if (created[id]) push_req(OP_READY, id, 5'($urandom()),
					16'($urandom()), $urandom());
				else push_req(OP_CREATE, id, 5'($urandom_range(0, 4)),
					16'($urandom_range(0, 3)), $urandom());
				6, 7, 8: push_req(OP_DELAY, 4'($urandom()), 5'($urandom()),
					16'($urandom()), rand_delay());
				9, 10, 11, 12, 13, 14, 15: push_req(OP_TICK, 4'($urandom()),
					5'($urandom()), 16'($urandom()), $urandom());
				16, 17, 18: push_req(OP_SCHED, 4'($urandom()), 5'($urandom()),
					16'($urandom()), $urandom());
				default: push_req(3'($urandom_range(5, 7)), 4'($urandom()),
					5'($urandom()), 16'($urandom()), $urandom());
			endcase
			k++;
		end
		stim_done = 1;
	end

	// reset, then finish on drain or timeout
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && pending_reqs.size() == 0 && !s_tvalid
			&& expected_results.size() == 0 || cycles >= LIMIT);
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("priority_task_scheduler_tb failed");
			$finish;
		end else begin
			repeat (50) @(posedge clk);
			$display("covered %0d requests, %0d results checked, %0d errors",
				requests_sent, results_seen, errors);
			if (errors == 0 && expected_results.size() == 0)
				$display("priority_task_scheduler_tb passed");
			else
				$display("priority_task_scheduler_tb failed");
			$finish;
		end
	end
endmodule
